### rtl/tfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfd_pkg: shared types and constants for the thermal fan duty block
// Duty constants, register indexes, controller states and divider handoff.
// ----------------------------------------------------------------------------
package tfd_pkg;

  localparam int unsigned TEMP_W  = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned RPM_W   = 16;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned QUO_W   = 7;   // quotient stays below the 80 percent span
  localparam int unsigned NUM_W   = 15;  // 80 * 255 fits in 15 bits

  localparam logic [TIME_W-1:0] STALE_MS   = 32'd30;
  localparam logic [TIME_W-1:0] STALL_MS   = 32'd2000;
  localparam logic [PCT_W-1:0]  FULL_DUTY  = 7'd100;
  localparam logic [PCT_W-1:0]  FLOOR_DUTY = 7'd20;

  // input action codes
  localparam logic ACT_REPORT = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_ACTIVE_MASK = 2'd0;
  localparam logic [1:0] CFG_START_THR   = 2'd1;
  localparam logic [1:0] CFG_FULL_THR    = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  typedef struct packed {
    logic              online;
    logic [TEMP_W-1:0] temp;
    logic [TIME_W-1:0] fb_time;
  } mem_word_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_res_t;

endpackage
`default_nettype wire

### rtl/tfd_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfd_div: restoring divider for the duty ramp
// One quotient bit per cycle; done pulses with the quotient after QUO_W steps.
// ----------------------------------------------------------------------------
module tfd_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [tfd_pkg::NUM_W-1:0] num,
  input  wire logic [tfd_pkg::TEMP_W-1:0] den,
  output tfd_pkg::div_res_t              res
);

  localparam int unsigned CNT_W = $clog2(tfd_pkg::QUO_W);

  logic                      busy_r;
  logic                      done_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [tfd_pkg::NUM_W-1:0] rem_r;
  logic [tfd_pkg::NUM_W-1:0] dsh_r;
  logic [tfd_pkg::QUO_W-1:0] quo_r;
  logic                      ge;

  assign ge = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      // divisor aligned to the top quotient bit
      dsh_r <= tfd_pkg::NUM_W'({den, {(tfd_pkg::QUO_W-1){1'b0}}});
      cnt_r <= CNT_W'(tfd_pkg::QUO_W - 1);
      quo_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r <= dsh_r >> 1;
      quo_r <= {quo_r[tfd_pkg::QUO_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;

endmodule
`default_nettype wire

### rtl/thermal_fan_duty_with_stall_detect.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thermal_fan_duty_with_stall_detect: fan duty from servo temperatures
// Report beat: writes the servo table, no result; back to back ok.
// Tick beat: scans the table, runs the divider, then presents one result;
//   one tick in flight, the input stalls until the result is registered.
// Reset (synchronous, rst_n low): table valid bits, stall timer, config regs
// (mask 0, thresholds 40 and 70) and output valid are cleared.
// ----------------------------------------------------------------------------
module thermal_fan_duty_with_stall_detect #(
  parameter int unsigned SERVO_COUNT = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  // input beats
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [2:0]  in_servo_index,
  input  wire logic        in_servo_online,
  input  wire logic [7:0]  in_servo_temp_c,
  input  wire logic [31:0] in_time_ms,
  input  wire logic        in_override_enable,
  input  wire logic [6:0]  in_override_percent,
  input  wire logic [15:0] in_tach_rpm,
  // result beats
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [6:0]       out_duty_percent,
  output logic             out_fan_stalled,
  output logic [15:0]      out_fan_rpm
);

  // Mask has 8 bits and the index 3, so only the first 8 servos ever matter.
  localparam int unsigned TBL_DEPTH = (SERVO_COUNT < 8) ? SERVO_COUNT : 8;
  localparam int unsigned TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam logic [TBL_AW-1:0] TBL_LAST = TBL_AW'(TBL_DEPTH - 1);

  tfd_pkg::state_t state_r;

  // config registers
  logic [7:0] active_mask_r;
  logic [7:0] start_thr_r;
  logic [7:0] full_thr_r;

  // servo table: one synchronous memory plus per-entry valid bits
  tfd_pkg::mem_word_t mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] vld_r;
  tfd_pkg::mem_word_t   rd_word_r;
  logic                 rd_ok_r;

  // scan control
  logic              issue_r;
  logic [TBL_AW-1:0] rd_addr_r;
  logic              rd_pend_r;
  logic [TBL_AW-1:0] rd_idx_r;

  // tick context and scan results
  logic [31:0] now_r;
  logic        ovr_en_r;
  logic [6:0]  ovr_pct_r;
  logic [15:0] rpm_r;
  logic [7:0]  hottest_r;
  logic        stale_r;

  logic        div_start_r;
  tfd_pkg::div_res_t div_res;
  logic [tfd_pkg::QUO_W-1:0] quo_r;

  logic [31:0] stall_start_r;

  logic out_valid_r;
  logic [6:0]  out_duty_r;
  logic        out_stalled_r;
  logic [15:0] out_rpm_r;

  logic in_acc;
  logic wr_en;
  logic rd_mask;
  logic rd_online;
  logic [31:0] rd_age;
  logic [7:0]  ramp_diff;
  logic [tfd_pkg::NUM_W-1:0] ramp_num;
  logic [7:0]  ramp_den;
  logic [6:0]  base_duty;
  logic [6:0]  ovr_sat;
  logic [6:0]  duty;
  logic        out_free;
  logic [31:0] stall_age;
  logic        stall_flag_nxt;
  logic [31:0] stall_start_nxt;

  assign in_stall = (state_r != tfd_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign wr_en    = in_acc && (in_action == tfd_pkg::ACT_REPORT)
                    && ({1'b0, in_servo_index} < 4'(TBL_DEPTH));

  // ---- config port ---------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_mask_r <= 8'd0;
      start_thr_r   <= 8'd40;
      full_thr_r    <= 8'd70;
    end else if (cfg_we) begin
      case (cfg_index)
        tfd_pkg::CFG_ACTIVE_MASK: active_mask_r <= cfg_wdata;
        tfd_pkg::CFG_START_THR:   start_thr_r   <= cfg_wdata;
        tfd_pkg::CFG_FULL_THR:    full_thr_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---- servo table ---------------------------------------------------------
  // Writes happen only in IDLE and read data is used only in SCAN, so a used
  // read never races a write to the same entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[in_servo_index[TBL_AW-1:0]] <= '{online:  in_servo_online,
                                           temp:    in_servo_temp_c,
                                           fb_time: in_time_ms};
    end
    rd_word_r <= mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[in_servo_index[TBL_AW-1:0]] <= 1'b1;
      end
      rd_ok_r <= vld_r[rd_addr_r];
    end
  end

  // ---- scan datapath -------------------------------------------------------
  // A never-written entry reads as offline, which is what reset leaves.
  assign rd_mask   = active_mask_r[3'(rd_idx_r)];
  assign rd_online = rd_ok_r && rd_word_r.online;
  assign rd_age    = now_r - rd_word_r.fb_time;

  always_ff @(posedge clk) begin
    if (in_acc && in_action == tfd_pkg::ACT_TICK) begin
      now_r     <= in_time_ms;
      ovr_en_r  <= in_override_enable;
      ovr_pct_r <= in_override_percent;
      rpm_r     <= in_tach_rpm;
      hottest_r <= 8'd0;
      stale_r   <= 1'b0;
    end else if (state_r == tfd_pkg::S_SCAN && rd_pend_r && rd_mask) begin
      if (!rd_online || rd_age > tfd_pkg::STALE_MS) begin
        stale_r <= 1'b1;
      end else if (rd_word_r.temp > hottest_r) begin
        hottest_r <= rd_word_r.temp;
      end
    end
    if (div_res.done) begin
      quo_r <= div_res.quo;
    end
    rd_idx_r <= rd_addr_r;
  end

  // ramp: 80 * (hottest - start) / (full - start), used only when in range
  assign ramp_diff = hottest_r - start_thr_r;
  assign ramp_num  = {1'b0, ramp_diff, 6'd0} + {3'd0, ramp_diff, 4'd0};
  assign ramp_den  = full_thr_r - start_thr_r;

  tfd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (ramp_num),
    .den   (ramp_den),
    .res   (div_res)
  );

  // ---- result and stall timer ----------------------------------------------
  always_comb begin
    if (stale_r || hottest_r >= full_thr_r) begin
      base_duty = tfd_pkg::FULL_DUTY;
    end else if (hottest_r <= start_thr_r) begin
      base_duty = tfd_pkg::FLOOR_DUTY;
    end else begin
      base_duty = tfd_pkg::FLOOR_DUTY + quo_r;
    end
    ovr_sat = (ovr_pct_r > tfd_pkg::FULL_DUTY) ? tfd_pkg::FULL_DUTY : ovr_pct_r;
    duty    = (ovr_en_r && ovr_sat > base_duty) ? ovr_sat : base_duty;

    stall_age = now_r - stall_start_r;
    if (duty < tfd_pkg::FLOOR_DUTY || rpm_r != 16'd0) begin
      stall_start_nxt = 32'd0;
      stall_flag_nxt  = 1'b0;
    end else if (stall_start_r == 32'd0) begin
      // zero start time is the idle marker
      stall_start_nxt = now_r;
      stall_flag_nxt  = 1'b0;
    end else begin
      stall_start_nxt = stall_start_r;
      stall_flag_nxt  = (stall_age >= tfd_pkg::STALL_MS);
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  // ---- control -------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= tfd_pkg::S_IDLE;
      issue_r       <= 1'b0;
      rd_addr_r     <= '0;
      rd_pend_r     <= 1'b0;
      div_start_r   <= 1'b0;
      stall_start_r <= 32'd0;
      out_valid_r   <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        tfd_pkg::S_IDLE: begin
          rd_pend_r <= 1'b0;
          if (in_acc && in_action == tfd_pkg::ACT_TICK) begin
            state_r   <= tfd_pkg::S_SCAN;
            issue_r   <= 1'b1;
            rd_addr_r <= '0;
          end
        end
        tfd_pkg::S_SCAN: begin
          rd_pend_r <= issue_r;
          if (issue_r) begin
            if (rd_addr_r == TBL_LAST) begin
              issue_r <= 1'b0;
            end else begin
              rd_addr_r <= rd_addr_r + 1'b1;
            end
          end
          if (rd_pend_r && rd_idx_r == TBL_LAST) begin
            state_r     <= tfd_pkg::S_DIV;
            div_start_r <= 1'b1;
          end
        end
        tfd_pkg::S_DIV: begin
          rd_pend_r <= 1'b0;
          if (div_res.done) begin
            state_r <= tfd_pkg::S_DONE;
          end
        end
        tfd_pkg::S_DONE: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            stall_start_r <= stall_start_nxt;
            state_r       <= tfd_pkg::S_IDLE;
          end
        end
        default: begin
          state_r <= tfd_pkg::S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == tfd_pkg::S_DONE && out_free) begin
      out_duty_r    <= duty;
      out_stalled_r <= stall_flag_nxt;
      out_rpm_r     <= rpm_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_duty_percent = out_duty_r;
  assign out_fan_stalled  = out_stalled_r;
  assign out_fan_rpm      = out_rpm_r;

  // ---- assertions ----------------------------------------------------------
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == tfd_pkg::S_DONE))
    else $error("result beat raised outside the finish state");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_duty_r >= tfd_pkg::FLOOR_DUTY &&
                     out_duty_r <= tfd_pkg::FULL_DUTY))
    else $error("duty outside the 20..100 range");

  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == tfd_pkg::S_DIV))
    else $error("divider finished outside the divide state");

  a_stall_zero_rpm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stalled_r) |-> (out_rpm_r == 16'd0))
    else $error("stall flagged with a nonzero tach reading");

endmodule
`default_nettype wire

### bench/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb: self-checking bench for thermal_fan_duty_with_stall_detect
// Servo report and tick beats go in through the valid/stall channel. A duty
// tracker keeps its own copy of the servo table, stall timer and registers,
// predicts every tick's duty, stall flag and rpm echo, and checks each result
// beat in order. Register settings change between phases while the block
// is idle. Both sides insert random gaps.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned SERVO_N    = 8;
  localparam int unsigned RAMP_SPAN  = 80;    // duty range from floor to full
  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_BEATS = 235;
  localparam int unsigned SETTLE     = 30;    // settle time after the last result

  typedef struct packed {
    logic        action;
    logic [2:0]  servo;
    logic        online;
    logic [7:0]  temp;
    logic [31:0] stamp;
    logic        ovr_en;
    logic [6:0]  ovr_pct;
    logic [15:0] rpm;
  } fan_beat_t;

  typedef struct packed {
    logic [6:0]  duty;
    logic        stalled;
    logic [15:0] rpm;
  } fan_result_t;

  // Tracks the servo table, stall timer and registers; queues the expected
  // result of every accepted tick and checks results against it.
  class duty_tracker;
    logic [7:0]  temp_tbl   [SERVO_N];
    logic        online_tbl [SERVO_N];
    logic [31:0] stamp_tbl  [SERVO_N];
    logic [31:0] zero_since;
    logic [7:0]  mask, start_c, full_c;
    fan_result_t pending[$];
    int unsigned errors, checked, ramps, stalls, reports;

    function new();
      int i;
      for (i = 0; i < SERVO_N; i++) begin
        temp_tbl[i]   = '0;
        online_tbl[i] = 1'b0;
        stamp_tbl[i]  = '0;
      end
      zero_since = '0;
      mask       = 8'd0;
      start_c    = 8'd40;
      full_c     = 8'd70;
      errors = 0; checked = 0; ramps = 0; stalls = 0; reports = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        tfd_pkg::CFG_ACTIVE_MASK: mask    = val;
        tfd_pkg::CFG_START_THR:   start_c = val;
        tfd_pkg::CFG_FULL_THR:    full_c  = val;
        default: ;
      endcase
    endfunction

    function logic [6:0] duty_for(logic [31:0] now);
      int i;
      int unsigned hottest, step;
      logic stale;
      logic [31:0] age;
      hottest = 0;
      stale   = 1'b0;
      for (i = 0; i < SERVO_N; i++) begin
        if (mask[i]) begin
          age = now - stamp_tbl[i];
          if (!online_tbl[i] || age > tfd_pkg::STALE_MS)
            stale = 1'b1;
          else if (temp_tbl[i] > hottest)
            hottest = 32'(temp_tbl[i]);
        end
      end
      if (stale || hottest >= full_c)
        return tfd_pkg::FULL_DUTY;
      if (hottest <= start_c)
        return tfd_pkg::FLOOR_DUTY;
      step = (RAMP_SPAN * (hottest - start_c)) / (full_c - start_c);
      return tfd_pkg::FLOOR_DUTY + step[6:0];
    endfunction

    function void note_beat(fan_beat_t b);
      fan_result_t r;
      logic [6:0]  req;
      logic [31:0] held;
      if (b.action == tfd_pkg::ACT_REPORT) begin
        reports++;
        if (b.servo < SERVO_N) begin
          temp_tbl[b.servo]   = b.temp;
          online_tbl[b.servo] = b.online;
          stamp_tbl[b.servo]  = b.stamp;
        end
        return;
      end
      r.duty = duty_for(b.stamp);
      req = (b.ovr_pct > tfd_pkg::FULL_DUTY) ? tfd_pkg::FULL_DUTY : b.ovr_pct;
      if (b.ovr_en && req > r.duty)
        r.duty = req;
      r.rpm = b.rpm;
      // zero start time doubles as the idle marker of the stall timer
      if (r.duty < tfd_pkg::FLOOR_DUTY || b.rpm != 16'd0) begin
        zero_since = '0;
        r.stalled  = 1'b0;
      end else if (zero_since == '0) begin
        zero_since = b.stamp;
        r.stalled  = 1'b0;
      end else begin
        held      = b.stamp - zero_since;
        r.stalled = (held >= tfd_pkg::STALL_MS);
      end
      pending.push_back(r);
    endfunction

    function void check_beat(fan_result_t got);
      fan_result_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: duty %0d stalled %0b rpm %0d",
                 $time, got.duty, got.stalled, got.rpm);
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (got.duty != exp_r.duty) begin
        errors++;
        $display("%0t: duty_percent expected %0d, actual %0d",
                 $time, exp_r.duty, got.duty);
      end
      if (got.stalled != exp_r.stalled) begin
        errors++;
        $display("%0t: fan_stalled expected %0b, actual %0b",
                 $time, exp_r.stalled, got.stalled);
      end
      if (got.rpm != exp_r.rpm) begin
        errors++;
        $display("%0t: fan_rpm expected %0d, actual %0d",
                 $time, exp_r.rpm, got.rpm);
      end
      if (exp_r.duty > tfd_pkg::FLOOR_DUTY && exp_r.duty < tfd_pkg::FULL_DUTY) ramps++;
      if (exp_r.stalled) stalls++;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_action;
  logic [2:0]  in_servo_index;
  logic        in_servo_online;
  logic [7:0]  in_servo_temp_c;
  logic [31:0] in_time_ms;
  logic        in_override_enable;
  logic [6:0]  in_override_percent;
  logic [15:0] in_tach_rpm;
  logic        out_valid;
  logic        out_stall;
  logic [6:0]  out_duty_percent;
  logic        out_fan_stalled;
  logic [15:0] out_fan_rpm;

  duty_tracker trk;
  int unsigned sent_beats;
  int unsigned settings_used;
  logic        in_no_gaps;     // sender runs back to back when set
  logic        out_no_stalls;  // receiver never holds off when set
  logic        zero_run;       // tach currently reading zero in random ticks
  logic [31:0] now_ms;         // running tick time of the random phases

  thermal_fan_duty_with_stall_detect #(.SERVO_COUNT(SERVO_N)) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_servo_index      (in_servo_index),
    .in_servo_online     (in_servo_online),
    .in_servo_temp_c     (in_servo_temp_c),
    .in_time_ms          (in_time_ms),
    .in_override_enable  (in_override_enable),
    .in_override_percent (in_override_percent),
    .in_tach_rpm         (in_tach_rpm),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_duty_percent    (out_duty_percent),
    .out_fan_stalled     (out_fan_stalled),
    .out_fan_rpm         (out_fan_rpm)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run (every tick with full gaps,
  // full receiver hold-off and its scan and divide).
  initial begin
    #10_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Result side: draw a random hold-off per beat (none when out_no_stalls is set), then take the next result.
  // The hold-off counts from the previous take, so it lands on every phase
  // of the block's scan and divide.
  initial begin : result_side
    int unsigned hold;
    fan_result_t got;
    out_stall = 1'b1;
    forever begin
      hold = out_no_stalls ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.duty    = out_duty_percent;
      got.stalled = out_fan_stalled;
      got.rpm     = out_fan_rpm;
      trk.check_beat(got);
    end
  end

  // Presents one beat after a random gap; returns at the edge it is taken.
  // Valid stays up afterwards; the next send or wait_idle decides its fate
  // at the following falling edge.
  task automatic send_beat(input fan_beat_t b);
    int unsigned gap;
    gap = in_no_gaps ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_action           <= b.action;
    in_servo_index      <= b.servo;
    in_servo_online     <= b.online;
    in_servo_temp_c     <= b.temp;
    in_time_ms          <= b.stamp;
    in_override_enable  <= b.ovr_en;
    in_override_percent <= b.ovr_pct;
    in_tach_rpm         <= b.rpm;
    do @(posedge clk); while (in_stall !== 1'b0);
    trk.note_beat(b);
    sent_beats++;
  endtask

  task automatic send_report(input logic [2:0] servo, input logic online,
                             input logic [7:0] temp, input logic [31:0] stamp);
    fan_beat_t b;
    b         = fan_beat_t'({5'($urandom), $urandom, $urandom});
    b.action  = tfd_pkg::ACT_REPORT;
    b.servo   = servo;
    b.online  = online;
    b.temp    = temp;
    b.stamp   = stamp;
    send_beat(b);
  endtask

  task automatic send_tick(input logic [31:0] stamp, input logic ovr_en,
                           input logic [6:0] ovr_pct, input logic [15:0] rpm);
    fan_beat_t b;
    b         = fan_beat_t'({5'($urandom), $urandom, $urandom});
    b.action  = tfd_pkg::ACT_TICK;
    b.stamp   = stamp;
    b.ovr_en  = ovr_en;
    b.ovr_pct = ovr_pct;
    b.rpm     = rpm;
    send_beat(b);
  endtask

  // Drops valid and waits until every expected result is in, then lets any
  // report still inside the block settle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (trk.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    trk.set_reg(idx, val);
  endtask

  task automatic set_regs(input logic [7:0] m, input logic [7:0] s, input logic [7:0] f);
    wait_idle();
    write_reg(tfd_pkg::CFG_ACTIVE_MASK, m);
    write_reg(tfd_pkg::CFG_START_THR, s);
    write_reg(tfd_pkg::CFG_FULL_THR, f);
    settings_used++;
  endtask

  // Mostly near the thresholds so the ramp and its edges get hit.
  function automatic logic [7:0] pick_temp();
    int lo, hi;
    lo = ((trk.start_c < trk.full_c) ? trk.start_c : trk.full_c) - 10;
    hi = ((trk.start_c < trk.full_c) ? trk.full_c : trk.start_c) + 10;
    if (lo < 0) lo = 0;
    if (hi > 255) hi = 255;
    if ($urandom_range(0, 99) < 15)
      return 8'($urandom_range(0, 255));
    return 8'($urandom_range(lo, hi));
  endfunction

  // One well-formed round: time moves on, some enabled servos report with
  // fresh or just-stale stamps, then one tick.
  task automatic run_round();
    int i;
    logic [15:0] rpm;
    if ($urandom_range(0, 9) < 7)
      now_ms += $urandom_range(0, 25);
    else
      now_ms += $urandom_range(100, 900);
    for (i = 0; i < SERVO_N; i++) begin
      if (trk.mask[i] && $urandom_range(0, 99) < 60)
        send_report(3'(i), $urandom_range(0, 19) != 0, pick_temp(),
                    now_ms - $urandom_range(0, 33));
    end
    if ($urandom_range(0, 9) == 0)
      zero_run = ~zero_run;
    rpm = zero_run ? 16'd0 : 16'($urandom_range(1, 65535));
    send_tick(now_ms, $urandom_range(0, 3) == 0, 7'($urandom_range(0, 127)), rpm);
  endtask

  initial begin : stimulus
    int unsigned ph, goal;
    logic [7:0] m, s, f;
    fan_beat_t noise;

    trk           = new();
    sent_beats    = 0;
    settings_used = 1;
    in_no_gaps    = 1'b0;
    out_no_stalls = 1'b0;
    zero_run      = 1'b0;
    now_ms        = '0;

    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = tfd_pkg::CFG_ACTIVE_MASK;
    cfg_wdata           = '0;
    in_valid            = 1'b0;
    in_action           = tfd_pkg::ACT_REPORT;
    in_servo_index      = '0;
    in_servo_online     = 1'b0;
    in_servo_temp_c     = '0;
    in_time_ms          = '0;
    in_override_enable  = 1'b0;
    in_override_percent = '0;
    in_tach_rpm         = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed part, reset registers: no servo enabled, ramp 40..70 ----
    // tach zero at time 0: timer start lands on the idle marker
    send_tick(32'd0, 1'b0, 7'd0, 16'd0);
    send_tick(32'd2500, 1'b0, 7'd0, 16'd0);       // timer really starts
    send_tick(32'd4499, 1'b0, 7'd0, 16'd0);       // one ms short of stall
    send_tick(32'd4500, 1'b0, 7'd0, 16'd0);       // stall flagged
    send_tick(32'd4501, 1'b1, 7'd127, 16'hFFFF);  // override saturates at 100
    send_tick(32'd4502, 1'b1, 7'd100, 16'd1);
    send_tick(32'd4503, 1'b1, 7'd0, 16'd0);       // override cannot lower

    // stamps just before the 32-bit wrap; servo 7 offline but masked out
    set_regs(8'h7F, 8'd40, 8'd70);
    send_report(3'd0, 1'b1, 8'd0,   32'hFFFF_FFF0);
    send_report(3'd1, 1'b1, 8'd45,  32'hFFFF_FFF0);
    send_report(3'd2, 1'b1, 8'd62,  32'hFFFF_FFF0);
    send_report(3'd3, 1'b1, 8'd41,  32'hFFFF_FFF0);
    send_report(3'd4, 1'b1, 8'd30,  32'hFFFF_FFF0);
    send_report(3'd5, 1'b1, 8'd55,  32'hFFFF_FFF0);
    send_report(3'd6, 1'b1, 8'd50,  32'hFFFF_FFF0);
    send_report(3'd7, 1'b0, 8'd255, 32'hFFFF_FFF0);
    send_tick(32'h0000_000E, 1'b0, 7'd0, 16'h1234);  // age exactly 30: ramp
    send_tick(32'h0000_000F, 1'b0, 7'd0, 16'h1234);  // age 31: stale

    set_regs(8'h80, 8'd40, 8'd70);                  // only the offline servo
    send_tick(32'h0000_000E, 1'b0, 7'd0, 16'd7);

    set_regs(8'h01, 8'd60, 8'd60);                  // equal thresholds
    send_report(3'd0, 1'b1, 8'd60, 32'd100);
    send_tick(32'd100, 1'b0, 7'd0, 16'd9);
    send_report(3'd0, 1'b1, 8'd59, 32'd100);
    send_tick(32'd100, 1'b0, 7'd0, 16'd9);

    // ---- random phases, one register setting each ----
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin m = 8'hFF; s = 8'd40; f = 8'd70; end
        1: begin m = 8'h00; s = 8'd0; f = 8'd0; end
        2: begin m = 8'($urandom); s = 8'd255; f = 8'd255; end
        3: begin m = 8'h01; s = 8'd0; f = 8'd255; end
        4: begin m = 8'($urandom); s = 8'd100; f = 8'd50; end   // inverted
        5: begin m = 8'($urandom); s = 8'd70; f = 8'd70; end
        6: begin
          m = 8'hFF;
          s = 8'($urandom_range(20, 60));
          f = 8'(s + $urandom_range(1, 80));
        end
        default: begin m = 8'($urandom); s = 8'($urandom); f = 8'($urandom); end
      endcase
      set_regs(m, s, f);
      in_no_gaps    = (ph % 3 == 1);
      out_no_stalls = (ph % 3 == 2);
      now_ms = (ph == 3) ? 32'hFFFF_F000 : $urandom;  // phase 3 crosses the wrap
      goal = sent_beats + PHASE_BEATS;
      while (sent_beats < goal) begin
        if ($urandom_range(0, 99) < 8) begin
          noise = fan_beat_t'({5'($urandom), $urandom, $urandom});
          send_beat(noise);
        end else begin
          run_round();
        end
        // hold the sender back until the block has drained
        if ($urandom_range(0, 99) == 0)
          wait_idle();
      end
    end

    wait_idle();
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d beats (%0d reports) over %0d register settings;",
             sent_beats, trk.reports, settings_used);
    $display("checked %0d tick results, %0d on the ramp, %0d flagging a stall.",
             trk.checked, trk.ramps, trk.stalls);
    if (trk.errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
